@@ rtl/core/sbsm_pkg.sv @@
// ----------------------------------------------------------------------------
// sbsm_pkg
// Types and constants shared by the serial bank switch mapper core: action
// codes, configuration register indexes, reset values and the state record.
// ----------------------------------------------------------------------------
package sbsm_pkg;

	// action codes of an input item
	typedef enum logic [1:0] {
		ACT_PRG_READ  = 2'd0,
		ACT_REG_WRITE = 2'd1,
		ACT_CHR_READ  = 2'd2
	} action_t;

	// configuration register indexes
	localparam logic CFG_PRG_BANK_COUNT = 1'b0;
	localparam logic CFG_CHR_BANKED     = 1'b1;

	// serial loader: five data bits above a marker, marker alone when empty
	localparam logic [5:0] LOADER_INIT = 6'd32;

	// reset values
	localparam logic [4:0] PRG_BANK_COUNT_RST = 5'd8;
	localparam logic       CHR_BANKED_RST     = 1'b1;
	localparam logic [1:0] PRG_MAP_FIXED_LAST = 2'd3;

	// program window layouts
	localparam logic [1:0] PRG_MAP_SWITCH_FIRST = 2'd2;

	// mapper state
	typedef struct packed {
		logic [5:0] loader;
		logic [1:0] prg_layout;
		logic       chr_layout;
		logic [1:0] mirror_mode;
		logic [3:0] prg_bank;
		logic [4:0] chr_bank_low;
		logic [4:0] chr_bank_high;
	} map_state_t;

endpackage

@@ rtl/core/serial_bank_switch_mapper_core.sv @@
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core
// Cartridge bank mapper: serial register loading from CPU writes, and
// program / pattern address mapping for CPU and PPU reads.
// ----------------------------------------------------------------------------
//
//  channel  | handshake           | payload
//  ---------+---------------------+------------------------------------------
//  input    | in_valid / in_ready | action, address, value
//  result   | out_valid/out_ready | prg_offset, chr_offset, mirroring
//  config   | cfg_we              | cfg_index, cfg_data
//
// One item per cycle sustained while the result is not stalled. Items pass an input register,
// then the mapping and register update logic into the result register.
// The mapper state changes when an item moves into the result register, so
// items are applied strictly in order. A stalled result holds the result
// register; the input register keeps taking items while the result
// register frees in the same cycle. Reset clears the pipeline and loads
// the power-up mapper state and configuration.
module serial_bank_switch_mapper_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [15:0] address,
	input  logic [7:0]  value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [17:0] prg_offset,
	output logic [16:0] chr_offset,
	output logic [1:0]  mirroring,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_data
);

	// configuration registers
	logic [4:0] prg_bank_count_q;
	logic       chr_banked_q;

	// input stage
	logic        valid_s1;
	logic [1:0]  action_s1;
	logic [15:0] address_s1;
	logic [7:0]  value_s1;

	// result stage
	logic        valid_s2;
	logic [17:0] prg_offset_s2;
	logic [16:0] chr_offset_s2;
	logic [1:0]  mirroring_s2;

	// mapper state
	sbsm_pkg::map_state_t state_q;
	sbsm_pkg::map_state_t state_next;

	logic        advance;
	logic [17:0] prg_off_c;
	logic [16:0] chr_off_c;

	// pipeline flow
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prg_bank_count_q <= sbsm_pkg::PRG_BANK_COUNT_RST;
			chr_banked_q     <= sbsm_pkg::CHR_BANKED_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				sbsm_pkg::CFG_PRG_BANK_COUNT: prg_bank_count_q <= cfg_data;
				sbsm_pkg::CFG_CHR_BANKED:     chr_banked_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			action_s1  <= action;
			address_s1 <= address;
			value_s1   <= value;
		end
	end

	// mapping and register update for the item in the input stage
	always_comb begin
		logic [3:0] prg_first;
		logic [3:0] prg_second;
		logic [3:0] prg_bank_sel;
		logic [4:0] chr_low;
		logic [4:0] chr_high;
		logic [4:0] chr_bank_sel;
		logic [4:0] last_bank;
		logic [5:0] shifted;
		logic [4:0] data;

		state_next = state_q;
		prg_off_c  = '0;
		chr_off_c  = '0;

		// program windows
		last_bank = prg_bank_count_q - 5'd1;
		case (state_q.prg_layout)
			sbsm_pkg::PRG_MAP_FIXED_LAST: begin
				prg_first  = state_q.prg_bank;
				prg_second = last_bank[3:0];
			end
			sbsm_pkg::PRG_MAP_SWITCH_FIRST: begin
				prg_first  = 4'd0;
				prg_second = state_q.prg_bank;
			end
			default: begin
				prg_first  = {state_q.prg_bank[3:1], 1'b0};
				prg_second = {state_q.prg_bank[3:1], 1'b1};
			end
		endcase
		prg_bank_sel = (address_s1[15:14] == 2'b11) ? prg_second : prg_first;

		// pattern windows
		if (state_q.chr_layout) begin
			chr_low  = state_q.chr_bank_low;
			chr_high = state_q.chr_bank_high;
		end else begin
			chr_low  = {state_q.chr_bank_low[4:1], 1'b0};
			chr_high = {state_q.chr_bank_low[4:1], 1'b1};
		end
		chr_bank_sel = (address_s1[15:12] != 4'd0) ? chr_high : chr_low;

		// serial loader
		shifted = {value_s1[0], state_q.loader[5:1]};
		data    = shifted[5:1];

		case (sbsm_pkg::action_t'(action_s1))
			sbsm_pkg::ACT_PRG_READ: begin
				prg_off_c = {prg_bank_sel, address_s1[13:0]};
			end
			sbsm_pkg::ACT_CHR_READ: begin
				if (chr_banked_q)
					chr_off_c = {chr_bank_sel, address_s1[11:0]};
				else
					chr_off_c = {4'd0, address_s1[12:0]};
			end
			sbsm_pkg::ACT_REG_WRITE: begin
				if (value_s1[7]) begin
					state_next.loader     = sbsm_pkg::LOADER_INIT;
					state_next.prg_layout = sbsm_pkg::PRG_MAP_FIXED_LAST;
				end else if (shifted[0]) begin
					// fifth bit in: commit by address range
					state_next.loader = sbsm_pkg::LOADER_INIT;
					case (address_s1[15:13]) inside
						[3'd0:3'd4]: begin
							state_next.mirror_mode = data[1:0];
							state_next.prg_layout  = data[3:2];
							state_next.chr_layout  = data[4];
						end
						3'd5:    state_next.chr_bank_low  = data;
						3'd6:    state_next.chr_bank_high = data;
						default: state_next.prg_bank      = data[3:0];
					endcase
				end else begin
					state_next.loader = shifted;
				end
			end
			default: ;
		endcase
	end

	// mapper state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.loader        <= sbsm_pkg::LOADER_INIT;
			state_q.prg_layout    <= sbsm_pkg::PRG_MAP_FIXED_LAST;
			state_q.chr_layout    <= 1'b0;
			state_q.mirror_mode   <= 2'd0;
			state_q.prg_bank      <= 4'd0;
			state_q.chr_bank_low  <= 5'd0;
			state_q.chr_bank_high <= 5'd0;
		end else if (advance) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prg_offset_s2 <= prg_off_c;
			chr_offset_s2 <= chr_off_c;
			mirroring_s2  <= state_next.mirror_mode;
		end
	end

	assign out_valid  = valid_s2;
	assign prg_offset = prg_offset_s2;
	assign chr_offset = chr_offset_s2;
	assign mirroring  = mirroring_s2;

	// checks
	a_loader_marker: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.loader != 6'd0)
		else $error("serial loader lost its marker bit");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2)
		else $error("input blocked with a free pipeline stage");

	a_single_offset: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (prg_offset_s2 == 18'd0 || chr_offset_s2 == 17'd0))
		else $error("result carries both a program and a pattern offset");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> $stable(state_q))
		else $error("mapper state changed with no item moving");

endmodule

@@ tb/serial_bank_switch_mapper_core_tb.sv @@
// ----------------------------------------------------------------------------
// serial_bank_switch_mapper_core_tb
// Self-checking bench for the serial bank switch mapper core. Bus accesses are
// fed through the valid/ready input channel, and a shadow copy of the mapper
// computes the expected offsets and mirroring for every accepted item.
// Results are compared in order, field by field. Several bank count and
// pattern memory settings are run, with random gaps on both channels.
// ----------------------------------------------------------------------------
module serial_bank_switch_mapper_core_tb;

	// action code with no meaning to the mapper
	localparam logic [1:0] ACT_UNUSED = 2'd3;

	localparam int unsigned CYCLE_LIMIT   = 400_000;
	localparam int unsigned PHASE_ITEMS   = 175;
	localparam int unsigned PHASES        = 8;
	localparam int unsigned PRINT_LIMIT   = 20;

	typedef struct packed {
		logic [1:0]  act;
		logic [15:0] addr;
		logic [7:0]  val;
	} bus_item_t;

	typedef struct packed {
		logic [17:0] prg;
		logic [16:0] chr;
		logic [1:0]  mirr;
	} map_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  action = sbsm_pkg::ACT_PRG_READ;
	logic [15:0] address = '0;
	logic [7:0]  value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [17:0] prg_offset;
	logic [16:0] chr_offset;
	logic [1:0]  mirroring;
	logic        cfg_we = 1'b0;
	logic        cfg_index = sbsm_pkg::CFG_PRG_BANK_COUNT;
	logic [4:0]  cfg_data = '0;

	// shadow mapper state and configuration
	sbsm_pkg::map_state_t mapper;
	logic [4:0]  bank_count;
	logic        chr_banked;

	bus_item_t   pending_items[$];
	map_result_t expected_results[$];

	int unsigned items_queued = 0;
	int unsigned items_taken = 0;
	int unsigned results_checked = 0;
	int unsigned loads_committed = 0;
	int unsigned settings_run = 0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	int unsigned in_gap = 0;
	int unsigned in_calm = 0;
	int unsigned out_stall = 0;
	int unsigned out_calm = 0;
	bus_item_t   next_item;

	serial_bank_switch_mapper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.action     (action),
		.address    (address),
		.value      (value),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prg_offset (prg_offset),
		.chr_offset (chr_offset),
		.mirroring  (mirroring),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	initial forever #4 clk = ~clk;

	// mapping of one bus access, updating the shadow state
	function automatic map_result_t map_access(input logic [1:0] act, input logic [15:0] addr,
			input logic [7:0] val);
		map_result_t res;
		logic [3:0]  first_bank;
		logic [3:0]  second_bank;
		logic [4:0]  low_bank;
		logic [4:0]  high_bank;
		logic [4:0]  load_data;
		logic [5:0]  shifted;
		res = '0;
		case (act)
			sbsm_pkg::ACT_PRG_READ: begin
				case (mapper.prg_layout)
					sbsm_pkg::PRG_MAP_SWITCH_FIRST: begin
						first_bank  = 4'd0;
						second_bank = mapper.prg_bank;
					end
					sbsm_pkg::PRG_MAP_FIXED_LAST: begin
						first_bank  = mapper.prg_bank;
						second_bank = 4'(bank_count - 5'd1);
					end
					default: begin
						// whole 32KB modes: even bank then the next one
						first_bank  = {mapper.prg_bank[3:1], 1'b0};
						second_bank = {mapper.prg_bank[3:1], 1'b1};
					end
				endcase
				res.prg = {(addr < 16'hC000) ? first_bank : second_bank, addr[13:0]};
			end
			sbsm_pkg::ACT_CHR_READ: begin
				if (!chr_banked) begin
					res.chr = {4'd0, addr[12:0]};
				end else begin
					if (mapper.chr_layout) begin
						low_bank  = mapper.chr_bank_low;
						high_bank = mapper.chr_bank_high;
					end else begin
						low_bank  = {mapper.chr_bank_low[4:1], 1'b0};
						high_bank = {mapper.chr_bank_low[4:1], 1'b1};
					end
					res.chr = {(addr < 16'h1000) ? low_bank : high_bank, addr[11:0]};
				end
			end
			sbsm_pkg::ACT_REG_WRITE: begin
				if (val[7]) begin
					mapper.loader     = sbsm_pkg::LOADER_INIT;
					mapper.prg_layout = sbsm_pkg::PRG_MAP_FIXED_LAST;
				end else begin
					shifted = {val[0], mapper.loader[5:1]};
					if (shifted[0]) begin
						// marker reached the bottom: fifth bit, commit by address
						load_data = shifted[5:1];
						if (addr < 16'hA000) begin
							mapper.mirror_mode = load_data[1:0];
							mapper.prg_layout  = load_data[3:2];
							mapper.chr_layout  = load_data[4];
						end else if (addr < 16'hC000) begin
							mapper.chr_bank_low = load_data;
						end else if (addr < 16'hE000) begin
							mapper.chr_bank_high = load_data;
						end else begin
							mapper.prg_bank = load_data[3:0];
						end
						mapper.loader = sbsm_pkg::LOADER_INIT;
						loads_committed++;
					end else begin
						mapper.loader = shifted;
					end
				end
			end
			default: begin
				// unused code: no state change
			end
		endcase
		res.mirr = mapper.mirror_mode;
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		mismatches++;
		if (mismatches <= PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s got 0x%0h want 0x%0h", cycles, what, got, want);
	endtask

	task automatic check_result();
		map_result_t want;
		if (expected_results.size() == 0) begin
			report_mismatch("result with no item outstanding", 32'(prg_offset), 0);
			return;
		end
		want = expected_results.pop_front();
		results_checked++;
		if (prg_offset !== want.prg)
			report_mismatch("prg_offset", 32'(prg_offset), 32'(want.prg));
		if (chr_offset !== want.chr)
			report_mismatch("chr_offset", 32'(chr_offset), 32'(want.chr));
		if (mirroring !== want.mirr)
			report_mismatch("mirroring", 32'(mirroring), 32'(want.mirr));
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_results.push_back(map_access(action, address, value));
				items_taken++;
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_valid <= 1'b0;
					in_gap--;
				end else if (pending_items.size() != 0) begin
					next_item = pending_items.pop_front();
					action   <= next_item.act;
					address  <= next_item.addr;
					value    <= next_item.val;
					in_valid <= 1'b1;
					if (in_calm > 0) begin
						in_calm--;
					end else begin
						in_gap = pick_gap();
						if ($urandom_range(0, 49) == 0)
							in_calm = $urandom_range(20, 60);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor with random back-pressure
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready)
				check_result();
			if (out_stall > 0) begin
				out_ready <= 1'b0;
				out_stall--;
			end else begin
				out_ready <= 1'b1;
				if (out_calm > 0) begin
					out_calm--;
				end else begin
					out_stall = pick_gap();
					if ($urandom_range(0, 49) == 0)
						out_calm = $urandom_range(20, 60);
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout: %0d items taken, %0d results checked", items_taken,
				results_checked);
			$display("** serial_bank_switch_mapper_core: FAILED **");
			$finish;
		end
	end

	task automatic push_item(input logic [1:0] act, input logic [15:0] addr,
			input logic [7:0] val);
		pending_items.push_back('{act: act, addr: addr, val: val});
		items_queued++;
	endtask

	// five serial writes, lowest bit first, random filler in the unused bits
	task automatic push_load(input logic [15:0] addr, input logic [4:0] data);
		logic [7:0] val;
		for (int i = 0; i < 5; i++) begin
			val    = 8'($urandom_range(0, 127));
			val[0] = data[i];
			push_item(sbsm_pkg::ACT_REG_WRITE, addr, val);
		end
	endtask

	task automatic push_read();
		logic [15:0] addr;
		if ($urandom_range(0, 1)) begin
			addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(16'h8000, 16'hFFFF));
			push_item(sbsm_pkg::ACT_PRG_READ, addr, 8'($urandom));
		end else begin
			addr = ($urandom_range(0, 9) == 0) ? 16'($urandom)
				: 16'($urandom_range(0, 16'h1FFF));
			push_item(sbsm_pkg::ACT_CHR_READ, addr, 8'($urandom));
		end
	endtask

	// one random sequence: mostly a full register load then reads
	task automatic push_sequence();
		int unsigned r;
		logic [15:0] addr;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			addr = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, 16'h7FFF))
				: 16'($urandom_range(16'h8000, 16'hFFFF));
			push_load(addr, 5'($urandom_range(0, 31)));
			repeat ($urandom_range(1, 6))
				push_read();
		end else if (r < 80) begin
			repeat ($urandom_range(1, 8))
				push_read();
		end else if (r < 90) begin
			// broken load: a few bits then a loader reset
			repeat ($urandom_range(1, 4))
				push_item(sbsm_pkg::ACT_REG_WRITE, 16'($urandom),
					8'($urandom_range(0, 127)));
			push_item(sbsm_pkg::ACT_REG_WRITE, 16'($urandom), 8'($urandom_range(128, 255)));
		end else begin
			push_item(2'($urandom_range(0, 3)), 16'($urandom), 8'($urandom));
		end
	endtask

	task automatic set_config(input logic idx, input logic [4:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		if (idx == sbsm_pkg::CFG_PRG_BANK_COUNT)
			bank_count = data;
		else
			chr_banked = data[0];
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait until every queued item has produced its result
	task automatic wait_drained();
		do
			@(negedge clk);
		while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [4:0] count_plan[6];
		logic       banked_plan[6];
		logic [4:0] count_pick;
		logic       banked_pick;
		int unsigned start;
		count_plan  = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd17, 5'd8};
		banked_plan = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};
		mapper      = '{loader: sbsm_pkg::LOADER_INIT,
			prg_layout: sbsm_pkg::PRG_MAP_FIXED_LAST, default: '0};
		bank_count  = sbsm_pkg::PRG_BANK_COUNT_RST;
		chr_banked  = sbsm_pkg::CHR_BANKED_RST;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed: power-up mapping, field extremes, odd addresses and codes
		push_item(sbsm_pkg::ACT_PRG_READ, 16'h8000, 8'h00);
		push_item(sbsm_pkg::ACT_PRG_READ, 16'hFFFF, 8'hFF);
		push_item(sbsm_pkg::ACT_CHR_READ, 16'h0000, 8'h00);
		push_item(sbsm_pkg::ACT_CHR_READ, 16'h1FFF, 8'h00);
		push_item(sbsm_pkg::ACT_CHR_READ, 16'hFFFF, 8'h00);
		push_item(ACT_UNUSED, 16'hFFFF, 8'hFF);
		push_item(sbsm_pkg::ACT_PRG_READ, 16'h0000, 8'h00);
		push_item(sbsm_pkg::ACT_REG_WRITE, 16'hE000, 8'h01);
		push_item(sbsm_pkg::ACT_REG_WRITE, 16'hE000, 8'h80);
		// bank value with bit 4 set, which the program bank drops
		push_load(16'hFFFF, 5'h1F);
		push_item(sbsm_pkg::ACT_PRG_READ, 16'hC000, 8'h00);
		push_item(sbsm_pkg::ACT_PRG_READ, 16'h7FFF, 8'h00);
		// control load from below the register window
		push_load(16'h0000, 5'b11010);
		push_item(sbsm_pkg::ACT_CHR_READ, 16'h1000, 8'h00);
		push_item(sbsm_pkg::ACT_REG_WRITE, 16'h0000, 8'h00);
		push_item(sbsm_pkg::ACT_REG_WRITE, 16'h0000, 8'hFF);
		wait_drained();
		settings_run++;

		for (int phase = 0; phase < PHASES; phase++) begin
			if (phase < 6) begin
				count_pick  = count_plan[phase];
				banked_pick = banked_plan[phase];
			end else begin
				count_pick  = 5'($urandom_range(0, 31));
				banked_pick = 1'($urandom_range(0, 1));
			end
			set_config(sbsm_pkg::CFG_PRG_BANK_COUNT, count_pick);
			set_config(sbsm_pkg::CFG_CHR_BANKED, {4'($urandom_range(0, 15)), banked_pick});
			start = items_queued;
			while (items_queued - start < PHASE_ITEMS)
				push_sequence();
			wait_drained();
			settings_run++;
		end

		repeat (10) @(posedge clk);
		$display("%0d bus items mapped, %0d results checked across %0d settings",
			items_taken, results_checked, settings_run);
		$display("%0d serial register loads committed, %0d mismatches", loads_committed,
			mismatches);
		if (mismatches == 0)
			$display("** serial_bank_switch_mapper_core: PASSED **");
		else
			$display("** serial_bank_switch_mapper_core: FAILED **");
		$finish;
	end

endmodule
